[sv/lbcg_pkg.sv]
`default_nettype none

package lbcg_pkg;

    localparam int LED_COUNT_DEF = 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam int STEPS_W       = 16;
    localparam int COLOR_W       = 32;
    localparam int TICK_W        = 32;
    localparam int LED_IDX_W     = 3;
    localparam int CHAN_W        = 8;
    localparam int CHAN_COUNT    = 4;
    // pos * code needs steps bits plus one byte
    localparam int PROD_W        = STEPS_W + CHAN_W;

    typedef enum logic
    {
        CMD_SET  = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        F_IDLE,
        F_DIV,
        F_SEND
    } front_state_t;

    typedef enum logic [2:0]
    {
        B_IDLE,
        B_READ,
        B_LOAD,
        B_MUL,
        B_DIV,
        B_OUT
    } back_state_t;

    // classified request handed from front to back
    typedef struct packed
    {
        cmd_t                   kind;
        logic [LED_IDX_W-1:0]   led;
        logic [COLOR_W-1:0]     color;
        logic [STEPS_W-1:0]     steps;
    } lbcg_op_t;

    // per-led state; r and phase track tick mod steps and the half period parity
    typedef struct packed
    {
        logic [COLOR_W-1:0]     color;
        logic [STEPS_W-1:0]     steps;
        logic [TICK_W-1:0]      tick;
        logic [STEPS_W-1:0]     r;
        logic                   phase;
    } lbcg_led_t;

    localparam lbcg_led_t LED_RESET = '{
        color: '0,
        steps: STEPS_W'(1),
        tick:  '0,
        r:     '0,
        phase: 1'b0
    };

endpackage

`default_nettype wire

[sv/led_breathing_color_generator.sv]
// RGBW breathing fade for a bank of LED_COUNT leds. A set request (command 0) stores one
// led's GRBW color, derives its half-period step count blink_time / (2 * loop_time) in a
// serial divider, and restarts that led's fade; it yields no result. A tick request
// (command 1) walks every led in order and yields one result per led, with last marking
// the final one. For each led, four serial dividers scale the four byte channels in
// parallel, and a result waits in the output register until it is popped.
// Requests are taken one at a time at the input and pass through a two-entry queue, so
// the next request is taken while a frame is still being produced. loop_time is written
// through cfg_we / cfg_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce; zero acts as one.
`default_nettype none

module led_breathing_color_generator
    import lbcg_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [15:0]          cfg_wdata,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 command,
    input  wire logic [LED_IDX_W-1:0] led_index,
    input  wire logic [COLOR_W-1:0]   color,
    input  wire logic [15:0]          blink_time,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [LED_IDX_W-1:0]      led_number,
    output logic [COLOR_W-1:0]        active_color,
    output logic                      last
);

    lbcg_op_t q_wr_data;
    lbcg_op_t q_rd_data;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;

    lbcg_front #(
        .LED_COUNT (LED_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .full       (full),
        .command    (command),
        .led_index  (led_index),
        .color      (color),
        .blink_time (blink_time),
        .q_push     (q_push),
        .q_data     (q_wr_data),
        .q_full     (q_full)
    );

    lbcg_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    lbcg_back #(
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (q_rd_data),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .led_number   (led_number),
        .active_color (active_color),
        .last         (last)
    );

endmodule

`default_nettype wire

[sv/lbcg_ram.sv]
`default_nettype none

module lbcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/lbcg_div.sv]
`default_nettype none

module lbcg_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic      [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] work_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] rem_next;

    // restoring division, one quotient bit per cycle shifted into the dividend
    always_comb
    begin
        trial    = {rem_reg, work_reg[NUM_W-1]};
        fits     = trial >= {1'b0, den_reg};
        diff     = trial - {1'b0, den_reg};
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= num;
            den_reg  <= den;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[NUM_W-2:0], fits};
            rem_reg  <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign quo  = work_reg;

endmodule

`default_nettype wire

[sv/lbcg_fifo.sv]
`default_nettype none

module lbcg_fifo
    import lbcg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire lbcg_op_t wr_data,
    output logic          full,
    input  wire logic     pop,
    output lbcg_op_t      rd_data,
    output logic          empty
);

    localparam int PTR_W = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    lbcg_op_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign full    = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[sv/lbcg_front.sv]
`default_nettype none

module lbcg_front
    import lbcg_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [15:0]          cfg_wdata,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 command,
    input  wire logic [LED_IDX_W-1:0] led_index,
    input  wire logic [COLOR_W-1:0]   color,
    input  wire logic [15:0]          blink_time,
    output logic                      q_push,
    output lbcg_op_t                  q_data,
    input  wire logic                 q_full
);

    front_state_t state_reg;
    front_state_t state_next;

    logic [15:0]          loop_time_reg;
    cmd_t                 kind_reg;
    logic [LED_IDX_W-1:0] led_reg;
    logic [COLOR_W-1:0]   color_reg;

    logic        accept;
    logic        in_range;
    logic        div_start;
    logic        div_busy;
    logic [15:0] div_quo;
    logic [15:0] lt_eff;

    assign accept   = push && !full;
    assign in_range = 32'(led_index) < LED_COUNT;
    assign lt_eff   = (loop_time_reg == '0) ? 16'd1 : loop_time_reg;

    // steps = blink_time / (2 * loop_time)
    lbcg_div #(
        .NUM_W (16),
        .DEN_W (17)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (blink_time),
        .den   ({lt_eff, 1'b0}),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_t'(command) == CMD_TICK)
                    begin
                        state_next = F_SEND;
                    end
                    else if (in_range)
                    begin
                        state_next = F_DIV;
                    end
                end
            end
            F_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = F_SEND;
                end
            end
            F_SEND:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        full      = 1'b1;
        q_push    = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                full      = 1'b0;
                div_start = accept && cmd_t'(command) == CMD_SET && in_range;
            end
            F_DIV:
            begin
                full = 1'b1;
            end
            F_SEND:
            begin
                q_push = !q_full;
            end
            default:
            begin
                full = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        q_data.kind  = kind_reg;
        q_data.led   = led_reg;
        q_data.color = color_reg;
        q_data.steps = (div_quo == '0) ? STEPS_W'(1) : div_quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            loop_time_reg <= 16'd1;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                loop_time_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= cmd_t'(command);
            led_reg   <= led_index;
            color_reg <= color;
        end
    end

endmodule

`default_nettype wire

[sv/lbcg_back.sv]
`default_nettype none

module lbcg_back
    import lbcg_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lbcg_op_t             q_data,
    input  wire logic                 q_empty,
    output logic                      q_pop,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [LED_IDX_W-1:0]      led_number,
    output logic [COLOR_W-1:0]        active_color,
    output logic                      last
);

    localparam int ADDR_W = LED_COUNT > 1 ? $clog2(LED_COUNT) : 1;
    localparam int ENTRY_W = $bits(lbcg_led_t);

    back_state_t state_reg;
    back_state_t state_next;

    logic [ADDR_W-1:0]    led_cnt_reg;
    logic [LED_COUNT-1:0] valid_reg;
    lbcg_led_t            cur_reg;

    logic                 out_valid_reg;
    logic [LED_IDX_W-1:0] out_num_reg;
    logic [COLOR_W-1:0]   out_color_reg;
    logic                 out_last_reg;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    lbcg_led_t            ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic                 is_set;
    logic                 slot_free;
    logic                 out_load;
    logic                 at_last;
    logic                 div_start;
    logic [CHAN_COUNT-1:0] lane_busy;
    logic [PROD_W-1:0]    lane_quo [CHAN_COUNT];
    logic [PROD_W-1:0]    lane_prod [CHAN_COUNT];
    logic [STEPS_W-1:0]   pos;
    lbcg_led_t            set_entry;
    lbcg_led_t            upd_entry;
    logic [STEPS_W:0]     r_inc;
    logic                 tick_wrap;
    logic                 half_end;
    logic [COLOR_W-1:0]   shaded;

    assign is_set    = !q_empty && q_data.kind == CMD_SET;
    assign slot_free = !out_valid_reg || pop;
    assign at_last   = led_cnt_reg == ADDR_W'(LED_COUNT - 1);

    lbcg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LED_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (led_cnt_reg),
        .rdata (ram_rdata)
    );

    // triangle position
    assign pos = cur_reg.phase ? cur_reg.steps - cur_reg.r : cur_reg.r;

    // one divider lane per byte channel, lane 3 is the top byte
    for (genvar i = 0; i < CHAN_COUNT; i++)
    begin : g_lane
        assign lane_prod[i] = PROD_W'(pos) * PROD_W'(cur_reg.color[i*CHAN_W +: CHAN_W]);

        lbcg_div #(
            .NUM_W (PROD_W),
            .DEN_W (STEPS_W)
        ) u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .num   (lane_prod[i]),
            .den   (cur_reg.steps),
            .busy  (lane_busy[i]),
            .quo   (lane_quo[i])
        );

        assign shaded[i*CHAN_W +: CHAN_W] = lane_quo[i][CHAN_W-1:0];
    end

    // tick advance keeps r = tick mod steps and phase = parity of tick / steps
    always_comb
    begin
        r_inc     = {1'b0, cur_reg.r} + (STEPS_W + 1)'(1);
        tick_wrap = &cur_reg.tick;
        half_end  = r_inc == {1'b0, cur_reg.steps};

        upd_entry       = cur_reg;
        upd_entry.tick  = cur_reg.tick + TICK_W'(1);
        upd_entry.r     = (tick_wrap || half_end) ? '0 : r_inc[STEPS_W-1:0];
        upd_entry.phase = tick_wrap ? 1'b0 : (half_end ? !cur_reg.phase : cur_reg.phase);

        set_entry       = LED_RESET;
        set_entry.color = q_data.color;
        set_entry.steps = q_data.steps;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty && q_data.kind == CMD_TICK)
                begin
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_LOAD;
            end
            B_LOAD:
            begin
                state_next = B_MUL;
            end
            B_MUL:
            begin
                state_next = B_DIV;
            end
            B_DIV:
            begin
                if (lane_busy == '0)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (slot_free)
                begin
                    state_next = at_last ? B_IDLE : B_READ;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = led_cnt_reg;
        ram_wdata = upd_entry;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                q_pop     = is_set;
                ram_we    = is_set;
                ram_waddr = ADDR_W'(q_data.led);
                ram_wdata = set_entry;
            end
            B_READ, B_LOAD, B_DIV:
            begin
                q_pop = 1'b0;
            end
            B_MUL:
            begin
                div_start = 1'b1;
            end
            B_OUT:
            begin
                out_load = slot_free;
                ram_we   = slot_free;
                q_pop    = slot_free && at_last;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            led_cnt_reg   <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (state_reg == B_IDLE)
            begin
                led_cnt_reg <= '0;
            end
            else if (out_load && !at_last)
            begin
                led_cnt_reg <= led_cnt_reg + ADDR_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_LOAD)
        begin
            // an entry never written reads as the reset state
            cur_reg <= valid_reg[led_cnt_reg] ? lbcg_led_t'(ram_rdata) : LED_RESET;
        end
        if (out_load)
        begin
            out_num_reg   <= LED_IDX_W'(led_cnt_reg);
            out_color_reg <= (cur_reg.steps <= STEPS_W'(1)) ? cur_reg.color : shaded;
            out_last_reg  <= at_last;
        end
    end

    assign empty        = !out_valid_reg;
    assign led_number   = out_num_reg;
    assign active_color = out_color_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire

[sv/lbcg_checker.sv]
`default_nettype none

module lbcg_checker #(
    parameter int LED_COUNT = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pop,
    input  wire logic        empty,
    input  wire logic [2:0]  led_number,
    input  wire logic [31:0] active_color,
    input  wire logic        last
);

    // led number expected on the next shown result
    logic [2:0] exp_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_num_reg <= '0;
        end
        else if (pop && !empty)
        begin
            exp_num_reg <= last ? 3'd0 : led_number + 3'd1;
        end
    end

    // the output valid flag is cleared asynchronously by reset
    a_empty_in_reset: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result shown during reset");

    a_led_order: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> led_number == exp_num_reg)
        else $error("results out of led order");

    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && last |-> led_number == 3'(LED_COUNT - 1))
        else $error("last flag on wrong led");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(led_number) && $stable(active_color)
            && $stable(last))
        else $error("waiting result changed");

endmodule

bind led_breathing_color_generator lbcg_checker #(
    .LED_COUNT (LED_COUNT)
) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop          (pop),
    .empty        (empty),
    .led_number   (led_number),
    .active_color (active_color),
    .last         (last)
);

`default_nettype wire
